>>> src/iagen_pkg.sv
package iagen_pkg;

	// geometry of the destination planes
	localparam int LANES      = 32;
	localparam int LANE_W     = $clog2(LANES);
	localparam int SLOT_ALIGN = 16;
	localparam int MAX_DIM    = 1024;

	// field and register widths
	localparam int COORD_W    = 10;
	localparam int TAPIN_W    = 4;
	localparam int DIM_W      = 11;
	localparam int CIN_W      = 6;
	localparam int CHAN_W     = 5;
	localparam int PLANE_W    = 8;
	localparam int PROD_W     = 14;
	localparam int SIGN_W     = PROD_W + 1;
	localparam int TAP_W      = 8;
	localparam int BASE_W     = 13;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 11;

	// decoupling queue
	localparam int QDEPTH  = 8;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);
	localparam int FLIGHT_W = 2;

	// widest channel count that still gets the sign flip
	localparam logic [CIN_W-1:0] FLIP_MAX_CIN = CIN_W'(3);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_CONV_STRIDE   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP       = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT      = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_HEIGHT  = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_WIDTH   = CFG_IDX_W'(7);

	typedef struct packed {
		logic [CIN_W-1:0]   channels_in;
		logic [TAPIN_W-1:0] kernel_height;
		logic [TAPIN_W-1:0] kernel_width;
		logic [TAPIN_W-1:0] conv_stride;
		logic [TAPIN_W-1:0] pad_top;
		logic [TAPIN_W-1:0] pad_left;
		logic [DIM_W-1:0]   input_height;
		logic [DIM_W-1:0]   input_width;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		channels_in:   CIN_W'(3),
		kernel_height: TAPIN_W'(3),
		kernel_width:  TAPIN_W'(3),
		conv_stride:   TAPIN_W'(1),
		pad_top:       TAPIN_W'(1),
		pad_left:      TAPIN_W'(1),
		input_height:  DIM_W'(224),
		input_width:   DIM_W'(224)
	};

	// one classified request, ready to be expanded over its channels
	typedef struct packed {
		logic [COORD_W-1:0] src_row;
		logic [COORD_W-1:0] src_col;
		logic               use_pad;
		logic               flip_sign;
		logic [BASE_W-1:0]  base;
		logic [CIN_W-1:0]   cin;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic   avail;
		entry_t entry;
	} head_t;

	typedef struct packed {
		logic [COORD_W-1:0] src_row;
		logic [COORD_W-1:0] src_col;
		logic [CHAN_W-1:0]  src_chan;
		logic               use_pad;
		logic [PLANE_W-1:0] dest_plane;
		logic [LANE_W-1:0]  dest_lane;
		logic               flip_sign;
		logic               last;
	} result_t;

endpackage

>>> src/iagen_front.sv
module iagen_front import iagen_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [COORD_W-1:0]  out_row,
	input  logic [COORD_W-1:0]  out_col,
	input  logic [TAPIN_W-1:0]  tap_row,
	input  logic [TAPIN_W-1:0]  tap_col,
	input  cfg_t                cfg,
	output push_t               push,
	output logic [FLIGHT_W-1:0] inflight
);

	logic               v_s1;
	logic [PROD_W-1:0]  oys_s1;
	logic [PROD_W-1:0]  oxs_s1;
	logic [TAP_W-1:0]   kyw_s1;
	logic [TAP_W-1:0]   khkw_s1;
	logic [TAPIN_W-1:0] ky_s1;
	logic [TAPIN_W-1:0] kx_s1;

	logic               v_s2;
	logic [COORD_W-1:0] src_row_s2;
	logic [COORD_W-1:0] src_col_s2;
	logic               use_pad_s2;
	logic               flip_s2;
	logic [TAP_W-1:0]   tap_s2;
	logic               packed_s2;
	logic [CIN_W-1:0]   cin_s2;

	logic [CIN_W-1:0]   cin_eff;
	logic [DIM_W-1:0]   ih_eff;
	logic [DIM_W-1:0]   iw_eff;
	logic [SIGN_W-1:0]  iy;
	logic [SIGN_W-1:0]  ix;
	logic               in_y;
	logic               in_x;
	logic               in_map;
	logic [PROD_W-1:0]  cells;
	logic [CIN_W-1:0]   rounded;
	logic [CIN_W-1:0]   slot;

	// clamp the oversized settings
	always_comb begin
		cin_eff = (cfg.channels_in > CIN_W'(LANES)) ? CIN_W'(LANES) : cfg.channels_in;
		ih_eff  = (cfg.input_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.input_height;
		iw_eff  = (cfg.input_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg.input_width;
	end

	// s1: the four products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			oys_s1  <= PROD_W'(out_row) * PROD_W'(cfg.conv_stride);
			oxs_s1  <= PROD_W'(out_col) * PROD_W'(cfg.conv_stride);
			kyw_s1  <= TAP_W'(tap_row) * TAP_W'(cfg.kernel_width);
			khkw_s1 <= TAP_W'(cfg.kernel_height) * TAP_W'(cfg.kernel_width);
			ky_s1   <= tap_row;
			kx_s1   <= tap_col;
		end
	end

	// s2: source position, border test and slot choice
	always_comb begin
		iy     = {1'b0, oys_s1} + SIGN_W'(ky_s1) - SIGN_W'(cfg.pad_top);
		ix     = {1'b0, oxs_s1} + SIGN_W'(kx_s1) - SIGN_W'(cfg.pad_left);
		in_y   = !iy[SIGN_W-1] && (iy[PROD_W-1:0] < PROD_W'(ih_eff));
		in_x   = !ix[SIGN_W-1] && (ix[PROD_W-1:0] < PROD_W'(iw_eff));
		in_map = in_y && in_x;
		cells  = PROD_W'(cin_eff) * PROD_W'(khkw_s1);
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			src_row_s2 <= in_map ? iy[COORD_W-1:0] : '0;
			src_col_s2 <= in_map ? ix[COORD_W-1:0] : '0;
			use_pad_s2 <= !in_map;
			flip_s2    <= in_map && (cin_eff <= FLIP_MAX_CIN);
			tap_s2     <= kyw_s1 + TAP_W'(kx_s1);
			packed_s2  <= cells <= PROD_W'(LANES);
			cin_s2     <= cin_eff;
		end
	end

	// tap base, written straight into the queue
	always_comb begin
		rounded = (cin_s2 + CIN_W'(SLOT_ALIGN - 1)) & ~CIN_W'(SLOT_ALIGN - 1);
		slot    = packed_s2 ? cin_s2 : rounded;
		push.valid           = v_s2 && (cin_s2 != '0);
		push.entry.src_row   = src_row_s2;
		push.entry.src_col   = src_col_s2;
		push.entry.use_pad   = use_pad_s2;
		push.entry.flip_sign = flip_s2;
		push.entry.base      = BASE_W'(BASE_W'(tap_s2) * BASE_W'(slot));
		push.entry.cin       = cin_s2;
	end

	assign inflight = FLIGHT_W'(v_s1) + FLIGHT_W'(v_s2);

endmodule

>>> src/iagen_queue.sv
module iagen_queue import iagen_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  push_t               push,
	input  logic                pop,
	input  logic [FLIGHT_W-1:0] inflight,
	output head_t               head,
	output logic                busy
);

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [QCNT_W:0]   occupancy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push.valid) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	// requests still in the front pipe have a queue slot reserved
	assign occupancy  = (QCNT_W+1)'(count_q) + (QCNT_W+1)'(inflight);
	assign busy       = occupancy >= (QCNT_W+1)'(QDEPTH);
	assign head.avail = count_q != '0;
	assign head.entry = mem_q[rd_ptr_q];

endmodule

>>> src/iagen_back.sv
module iagen_back import iagen_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  head_t   head,
	output logic    pop,
	output logic    strobe,
	output result_t res
);

	logic              active_q;
	logic [CHAN_W-1:0] chan_q;
	entry_t            cur_q;
	logic              strobe_q;
	result_t           res_q;
	logic              is_last;
	logic [BASE_W-1:0] pc;

	assign is_last = active_q && (CIN_W'(chan_q) == cur_q.cin - CIN_W'(1));
	assign pop     = head.avail && (!active_q || is_last);
	assign pc      = cur_q.base + BASE_W'(chan_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			chan_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				chan_q   <= '0;
			end else if (is_last) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				chan_q <= chan_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.entry;
		end
		if (active_q) begin
			res_q.src_row    <= cur_q.src_row;
			res_q.src_col    <= cur_q.src_col;
			res_q.src_chan   <= chan_q;
			res_q.use_pad    <= cur_q.use_pad;
			res_q.dest_plane <= pc[BASE_W-1:LANE_W];
			res_q.dest_lane  <= pc[LANE_W-1:0];
			res_q.flip_sign  <= cur_q.flip_sign;
			res_q.last       <= is_last;
		end
	end

	assign strobe = strobe_q;
	assign res    = res_q;

endmodule

>>> src/im2col_tap_address_generator_unit.sv
// im2col tap address generator
//
// request channel: a request (out_row, out_col, tap_row, tap_col) is taken
// at a rising edge with start high and busy low. busy rises once the eight
// queue slots are all filled or held for requests still in the front stages.
// result channel: one beat per input channel, c = 0 .. channels_in-1, each
// shown for one cycle under result_strobe; last marks the final beat.
// the receiver cannot stall, so beats leave at one per cycle with no gaps
// while requests are queued.
// path: a request passes the s1 and s2 front stages, the queue, the channel
// sequencer and the result register before its first beat appears.
// throughput: one beat per cycle while requests are queued; a request
// gives channels_in beats (above 32 counts as 32), bound by the single
// channel sequencer at the back; requests with zero channels give no beats.
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high, indexes past the last register are dropped. write only
// while no request is in flight.
// reset: arst_n clears the queue and the sequencer at once and loads the
// register defaults; no clearing pass is needed.
module im2col_tap_address_generator_unit import iagen_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  start,
	output logic                  busy,
	input  logic [COORD_W-1:0]    out_row,
	input  logic [COORD_W-1:0]    out_col,
	input  logic [TAPIN_W-1:0]    tap_row,
	input  logic [TAPIN_W-1:0]    tap_col,
	// config channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// result channel
	output logic                  result_strobe,
	output logic [COORD_W-1:0]    src_row,
	output logic [COORD_W-1:0]    src_col,
	output logic [CHAN_W-1:0]     src_chan,
	output logic                  use_pad,
	output logic [PLANE_W-1:0]    dest_plane,
	output logic [LANE_W-1:0]     dest_lane,
	output logic                  flip_sign,
	output logic                  last
);

	cfg_t                cfg_q;
	logic                accept;
	push_t               push;
	head_t               head;
	logic                pop;
	logic [FLIGHT_W-1:0] inflight;
	result_t             res;

	// register file, each field masked to its own width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CHANNELS_IN:   cfg_q.channels_in   <= cfg_data[CIN_W-1:0];
				REG_KERNEL_HEIGHT: cfg_q.kernel_height <= cfg_data[TAPIN_W-1:0];
				REG_KERNEL_WIDTH:  cfg_q.kernel_width  <= cfg_data[TAPIN_W-1:0];
				REG_CONV_STRIDE:   cfg_q.conv_stride   <= cfg_data[TAPIN_W-1:0];
				REG_PAD_TOP:       cfg_q.pad_top       <= cfg_data[TAPIN_W-1:0];
				REG_PAD_LEFT:      cfg_q.pad_left      <= cfg_data[TAPIN_W-1:0];
				REG_INPUT_HEIGHT:  cfg_q.input_height  <= cfg_data[DIM_W-1:0];
				REG_INPUT_WIDTH:   cfg_q.input_width   <= cfg_data[DIM_W-1:0];
				default: begin
					// unmapped index, nothing to write
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// front: products, border test, slot and tap base
	iagen_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.out_row  (out_row),
		.out_col  (out_col),
		.tap_row  (tap_row),
		.tap_col  (tap_col),
		.cfg      (cfg_q),
		.push     (push),
		.inflight (inflight)
	);

	// queue between classification and channel expansion
	iagen_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.inflight (inflight),
		.head     (head),
		.busy     (busy)
	);

	// back: one beat per channel
	iagen_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.strobe (result_strobe),
		.res    (res)
	);

	assign src_row    = res.src_row;
	assign src_col    = res.src_col;
	assign src_chan   = res.src_chan;
	assign use_pad    = res.use_pad;
	assign dest_plane = res.dest_plane;
	assign dest_lane  = res.dest_lane;
	assign flip_sign  = res.flip_sign;
	assign last       = res.last;

endmodule

>>> src/iagen_checker.sv
module iagen_checker import iagen_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  result_strobe,
	input logic [COORD_W-1:0]    src_row,
	input logic [COORD_W-1:0]    src_col,
	input logic [CHAN_W-1:0]     src_chan,
	input logic                  use_pad,
	input logic [PLANE_W-1:0]    dest_plane,
	input logic [LANE_W-1:0]     dest_lane,
	input logic                  flip_sign,
	input logic                  last
);

	// a border beat carries no source position and no flip
	a_pad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && use_pad |-> src_row == '0 && src_col == '0 && !flip_sign)
		else $error("border beat with source position or flip");

	// within a request the channel steps by one each cycle
	a_chan_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |=> result_strobe && src_chan == $past(src_chan) + 1'b1)
		else $error("channel run broken");

	// the pseudo-channel steps by one across lanes and planes
	a_pc_step: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |=>
			{dest_plane, dest_lane} == $past({dest_plane, dest_lane}) + 1'b1)
		else $error("pseudo-channel not contiguous");

	// a new request always opens at channel zero
	a_chan_open: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last |=> !result_strobe || src_chan == '0)
		else $error("request did not start at channel zero");

	// source coordinates hold across one request
	a_src_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |=> $stable(src_row) && $stable(src_col) && $stable(use_pad))
		else $error("source moved inside a request");

endmodule

bind im2col_tap_address_generator_unit iagen_checker u_iagen_checker (.*);
